// ===== src/ssf_pkg.sv =====
package ssf_pkg;

  localparam logic [7:0] SyncFirst  = 8'hA5;
  localparam logic [7:0] SyncSecond = 8'h5A;
  localparam logic [7:0] VersionByte = 8'h01;
  localparam logic [7:0] ConstOne   = 8'h01;
  localparam logic [7:0] StatusMask = 8'hF0;
  localparam logic [7:0] StatusGood = 8'hC0;
  localparam logic [9:0] MsToUs     = 10'd1000;
  localparam logic [4:0] LastInPos  = 5'd26;
  localparam logic [2:0] ModeReset  = 3'd1;
  localparam int unsigned QueueDepth = 2;

  // input mode codes
  localparam logic [2:0] ModeBiasPn  = 3'd0;
  localparam logic [2:0] ModeBiasP   = 3'd1;
  localparam logic [2:0] ModeBiasOff = 3'd2;
  localparam logic [2:0] ModeShorted = 3'd3;
  localparam logic [2:0] ModeTest    = 3'd4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        ready_was_low;
    logic [31:0] uptime_ms;
    logic [15:0] read_duration_us;
  } ssf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
  } ssf_out_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_FIRST,
    KIND_FLAG,
    KIND_LAST
  } ssf_kind_t;

  // word0: sequence / flag byte / {mode, read time}; word1: uptime in us
  typedef struct packed {
    ssf_kind_t   kind;
    logic [7:0]  data;
    logic [31:0] word0;
    logic [31:0] word1;
  } ssf_entry_t;

  typedef struct packed {
    logic       valid;
    ssf_entry_t entry;
  } ssf_slot_t;

endpackage

// ===== src/ssf_front.sv =====
module ssf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssf_pkg::ssf_in_t in_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_wdata,
  input  logic             queue_full,
  output ssf_pkg::ssf_slot_t push
);
  import ssf_pkg::*;

  logic [4:0]  byte_position;
  logic [31:0] frame_sequence;
  logic        held_ready_flag;
  logic        held_status_match;
  logic [2:0]  input_mode;
  logic        accept;
  logic [31:0] uptime_us;
  logic [7:0]  flags;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  // product kept modulo 2^32
  assign uptime_us = in_data.uptime_ms * 32'(MsToUs);

  always_comb begin
    flags    = '0;
    flags[0] = held_status_match;
    flags[1] = held_ready_flag;
    flags[3] = (input_mode == ModeTest);
    flags[4] = (input_mode == ModeShorted);
    flags[5] = (input_mode <= ModeBiasP);
    flags[6] = (input_mode == ModeBiasPn);
    flags[7] = (input_mode <= ModeBiasOff);
  end

  always_comb begin
    push.valid       = accept;
    push.entry.data  = in_data.data_byte;
    push.entry.kind  = KIND_PLAIN;
    push.entry.word0 = '0;
    push.entry.word1 = '0;
    if (byte_position == 5'd0) begin
      push.entry.kind  = KIND_FIRST;
      push.entry.word0 = frame_sequence;
      push.entry.word1 = uptime_us;
    end else if (byte_position == 5'd2) begin
      push.entry.kind  = KIND_FLAG;
      push.entry.word0 = {24'd0, flags};
    end else if (byte_position >= LastInPos) begin
      push.entry.kind  = KIND_LAST;
      push.entry.word0 = {13'd0, input_mode, in_data.read_duration_us};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      frame_sequence    <= '0;
      held_ready_flag   <= 1'b0;
      held_status_match <= 1'b0;
      input_mode        <= ModeReset;
    end else begin
      if (cfg_we) begin
        input_mode <= cfg_wdata;
      end
      if (accept) begin
        if (byte_position == 5'd0) begin
          held_status_match <= ((in_data.data_byte & StatusMask) == StatusGood);
          held_ready_flag   <= in_data.ready_was_low;
          frame_sequence    <= frame_sequence + 32'd1;
        end
        if (byte_position >= LastInPos) begin
          byte_position <= '0;
        end else begin
          byte_position <= byte_position + 5'd1;
        end
      end
    end
  end

endmodule

// ===== src/ssf_queue.sv =====
module ssf_queue (
  input  logic               clk,
  input  logic               rst,
  input  ssf_pkg::ssf_slot_t push,
  output logic               full,
  input  logic               pop,
  output ssf_pkg::ssf_slot_t head
);
  import ssf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  ssf_entry_t      slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            do_pop;

  assign full       = (count == (PtrW+1)'(QueueDepth));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + (PtrW+1)'(1);
        2'b01:   count <= count - (PtrW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/ssf_back.sv =====
module ssf_back (
  input  logic               clk,
  input  logic               rst,
  input  ssf_pkg::ssf_slot_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ssf_pkg::ssf_out_t  out_data
);
  import ssf_pkg::*;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [3:0]  idx;
  logic [15:0] crc;
  logic [15:0] crc_in;
  logic [3:0]  last_idx;
  logic [7:0]  cur_byte;
  logic        feed;
  logic        advance;
  logic        run_last;
  ssf_entry_t  e;

  assign e        = head.entry;
  assign advance  = head.valid && (!out_valid || out_ready);
  assign run_last = (idx == last_idx);
  assign pop      = advance && run_last;
  assign crc_in   = (e.kind == KIND_FIRST && idx == 4'd0) ? 16'hFFFF : crc;
  assign feed     = !(e.kind == KIND_LAST && idx >= 4'd7);

  always_comb begin
    case (e.kind)
      KIND_FIRST: last_idx = 4'd12;
      KIND_FLAG:  last_idx = 4'd1;
      KIND_LAST:  last_idx = 4'd8;
      default:    last_idx = 4'd0;
    endcase
  end

  always_comb begin
    cur_byte = e.data;
    case (e.kind)
      KIND_FIRST: begin
        case (idx) inside
          4'd0:          cur_byte = SyncFirst;
          4'd1:          cur_byte = SyncSecond;
          4'd2, 4'd3:    cur_byte = VersionByte;
          [4'd4:4'd7]:   cur_byte = e.word0[8*idx[1:0] +: 8];
          [4'd8:4'd11]:  cur_byte = e.word1[8*idx[1:0] +: 8];
          default:       cur_byte = e.data;
        endcase
      end
      KIND_FLAG: begin
        cur_byte = (idx == 4'd0) ? e.data : e.word0[7:0];
      end
      KIND_LAST: begin
        case (idx)
          4'd1:    cur_byte = e.word0[7:0];
          4'd2:    cur_byte = e.word0[15:8];
          4'd3:    cur_byte = ConstOne;
          4'd4:    cur_byte = {5'd0, e.word0[18:16]};
          4'd5:    cur_byte = 8'h00;
          4'd6:    cur_byte = 8'h00;
          4'd7:    cur_byte = crc[7:0];
          4'd8:    cur_byte = crc[15:8];
          default: cur_byte = e.data;
        endcase
      end
      default: cur_byte = e.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= 16'hFFFF;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid          <= 1'b1;
        out_data.out_byte  <= cur_byte;
        out_data.run_end   <= run_last;
        out_data.frame_end <= (e.kind == KIND_LAST) && run_last;
        idx                <= run_last ? 4'd0 : idx + 4'd1;
        if (feed) begin
          crc <= crc_byte(crc_in, cur_byte);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/sample_stream_framer_crc16.sv =====
// the first output byte of a transaction passes through a queue slot and then the back end's output register
// throughput: one output byte per cycle while the queue holds an entry and out_ready is high; a frame of 27
// input bytes gives 48 output bytes through the single output byte lane of the back end
// input is taken every cycle while the 2-entry queue between front and back has room
// reset (synchronous, active high) clears position, sequence, queue and output;
// the input mode register returns to 1
module sample_stream_framer_crc16 (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssf_pkg::ssf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ssf_pkg::ssf_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata
);
  import ssf_pkg::*;

  ssf_slot_t push;
  ssf_slot_t head;
  logic      queue_full;
  logic      pop;

  ssf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .queue_full(queue_full),
    .push      (push)
  );

  ssf_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .full(queue_full),
    .pop (pop),
    .head(head)
  );

  ssf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== src/ssf_checker.sv =====
module ssf_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input ssf_pkg::ssf_out_t out_data
);
  import ssf_pkg::*;

  logic out_acc;
  logic frame_start;

  assign out_acc = out_valid && out_ready;

  // next output transaction opens a new frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
    end else if (out_acc) begin
      frame_start <= out_data.frame_end;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_frame_end_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.run_end)
    else $error("frame end without run end");

  a_frame_starts_sync: assert property (@(posedge clk) disable iff (rst)
    out_acc && frame_start |-> out_data.out_byte == SyncFirst && !out_data.run_end)
    else $error("frame does not open with sync byte");

endmodule

bind sample_stream_framer_crc16 ssf_checker u_ssf_checker (.*);

// ===== verif/ssf_frame_checker.sv =====
module ssf_frame_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ssf_pkg::ssf_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ssf_pkg::ssf_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  output int                mismatch_count,
  output int                bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int         ReportLimit   = 10;

  logic [2:0]  mode_q;
  logic [4:0]  pos_q;
  logic [31:0] seq_q;
  logic [15:0] crc_q;
  logic        ready_flag_q;
  logic        status_ok_q;
  int          bytes_seen;
  ssf_out_t    frame_bytes_q[$];

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic feed, input logic last);
    ssf_out_t o;
    if (feed) begin
      crc_q = crc16_ccitt_byte(crc_q, b);
    end
    o.out_byte  = b;
    o.run_end   = 1'b0;
    o.frame_end = last;
    frame_bytes_q.push_back(o);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      push_byte(w[8*i +: 8], 1'b1, 1'b0);
    end
  endtask

  task automatic predict_frame_bytes(input ssf_in_t it);
    logic [7:0]  flags;
    logic [31:0] uptime_us;
    logic [15:0] crc_snap;
    ssf_out_t    tail;
    if (pos_q == 5'd0) begin
      crc_q        = 16'hFFFF;
      status_ok_q  = (it.data_byte & StatusMask) == StatusGood;
      ready_flag_q = it.ready_was_low;
      push_byte(SyncFirst, 1'b1, 1'b0);
      push_byte(SyncSecond, 1'b1, 1'b0);
      push_byte(VersionByte, 1'b1, 1'b0);
      push_byte(VersionByte, 1'b1, 1'b0);
      push_word(seq_q);
      uptime_us = it.uptime_ms * 32'(MsToUs);
      push_word(uptime_us);
      push_byte(it.data_byte, 1'b1, 1'b0);
      seq_q = seq_q + 32'd1;
    end else if (pos_q == 5'd2) begin
      flags    = '0;
      flags[0] = status_ok_q;
      flags[1] = ready_flag_q;
      flags[3] = mode_q == ModeTest;
      flags[4] = mode_q == ModeShorted;
      flags[5] = mode_q <= ModeBiasP;
      flags[6] = mode_q == ModeBiasPn;
      flags[7] = mode_q <= ModeBiasOff;
      push_byte(it.data_byte, 1'b1, 1'b0);
      push_byte(flags, 1'b1, 1'b0);
    end else if (pos_q >= LastInPos) begin
      push_byte(it.data_byte, 1'b1, 1'b0);
      push_byte(it.read_duration_us[7:0], 1'b1, 1'b0);
      push_byte(it.read_duration_us[15:8], 1'b1, 1'b0);
      push_byte(ConstOne, 1'b1, 1'b0);
      push_byte({5'b0, mode_q}, 1'b1, 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);
      push_byte(8'h00, 1'b1, 1'b0);
      crc_snap = crc_q;
      push_byte(crc_snap[7:0], 1'b0, 1'b0);
      push_byte(crc_snap[15:8], 1'b0, 1'b1);
    end else begin
      push_byte(it.data_byte, 1'b1, 1'b0);
    end
    // last byte caused by this transaction carries run_end
    tail = frame_bytes_q.pop_back();
    tail.run_end = 1'b1;
    frame_bytes_q.push_back(tail);
    pos_q = (pos_q >= LastInPos) ? 5'd0 : pos_q + 5'd1;
  endtask

  always @(posedge clk) begin
    ssf_out_t want;
    if (rst) begin
      mode_q         = ModeReset;
      pos_q          = '0;
      seq_q          = '0;
      crc_q          = 16'hFFFF;
      ready_flag_q   = 1'b0;
      status_ok_q    = 1'b0;
      bytes_seen     = 0;
      mismatch_count = 0;
      frame_bytes_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_frame_bytes(in_data);
      end
      if (out_valid && out_ready) begin
        if (frame_bytes_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("output %0d: unexpected byte %h run_end %b frame_end %b",
                     bytes_seen, out_data.out_byte, out_data.run_end, out_data.frame_end);
          end
        end else begin
          want = frame_bytes_q.pop_front();
          if (want.out_byte !== out_data.out_byte || want.run_end !== out_data.run_end ||
              want.frame_end !== out_data.frame_end) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("output %0d: expected byte %h run_end %b frame_end %b, got %h %b %b",
                       bytes_seen, want.out_byte, want.run_end, want.frame_end,
                       out_data.out_byte, out_data.run_end, out_data.frame_end);
            end
          end
        end
        bytes_seen++;
      end
      // register takes effect after this edge
      if (cfg_we) begin
        mode_q = cfg_wdata;
      end
    end
    bytes_pending = frame_bytes_q.size();
  end

endmodule

// ===== verif/sample_stream_framer_crc16_tb.sv =====
module sample_stream_framer_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int FramesTotal   = 14;
  localparam int FrameLen      = 27;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  ssf_in_t    in_data   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_wdata = '0;
  logic       in_ready;
  logic       out_valid;
  ssf_out_t   out_data;
  int         mismatches;
  int         pending;
  int         send_idle_pct = 9;
  int         recv_idle_pct = 45;
  int         stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  sample_stream_framer_crc16 u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ssf_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatches),
    .bytes_pending  (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // returns at the edge where the transaction is accepted; valid stays up
  task automatic send_byte(input ssf_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drain every outstanding byte, then write the mode register
  task automatic settle_then_configure(input logic [2:0] mode);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_frame(input bit directed);
    ssf_in_t it;
    for (int p = 0; p < FrameLen; p++) begin
      it.data_byte        = 8'($urandom);
      it.ready_was_low    = 1'($urandom);
      it.uptime_ms        = ($urandom_range(3) == 0) ? '0 : 32'($urandom);
      it.read_duration_us = ($urandom_range(3) == 0) ? '0 : 16'($urandom);
      if (p == 0 && $urandom_range(1) == 0) begin
        it.data_byte[7:4] = StatusGood[7:4];
      end
      if (directed) begin
        it.data_byte = p[0] ? 8'hFF : 8'h00;
        if (p == 0) begin
          it.data_byte     = StatusGood;
          it.ready_was_low = 1'b1;
          it.uptime_ms     = '1;
        end
        if (p == FrameLen - 1) begin
          it.read_duration_us = '1;
          // mode byte takes the value present when the last input arrives
          settle_then_configure('1);
        end
      end else if ($urandom_range(19) == 0) begin
        settle_then_configure(3'($urandom_range(7)));
      end
      send_byte(it);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int f = 0; f < FramesTotal; f++) begin
      if (f == 5) begin
        send_idle_pct = 45;
        recv_idle_pct = 9;
      end else if (f == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // sweeps all mode codes; the first frame runs with the reset mode
      if (f > 0) begin
        settle_then_configure(3'(f));
      end
      send_frame(f == 0);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ssf_pkg.sv
src/ssf_front.sv
src/ssf_queue.sv
src/ssf_back.sv
src/sample_stream_framer_crc16.sv
src/ssf_checker.sv
verif/ssf_frame_checker.sv
verif/sample_stream_framer_crc16_tb.sv
